// File: hw/rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int STREAMS        = 8;
	localparam int SLOT_W         = 3;
	localparam int MAX_FRAGS      = 64;
	localparam int MAX_FRAG_BYTES = 256;
	localparam logic [14:0] LEN_MAX = 15'h7fff;

	localparam logic [2:0] ST_SINGLE    = 3'd0;
	localparam logic [2:0] ST_WAITING   = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_COMPLETE  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_MISMATCH  = 3'd5;
	localparam logic [2:0] ST_TOO_MANY  = 3'd6;
	localparam logic [2:0] ST_EXPIRED   = 3'd7;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_LIMIT   = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_UPDATE,
		S_EXPIRE,
		S_OUT
	} frt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic update;
		logic expire;
		logic out_take;
	} frt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_expire;
		logic quick;
		logic scan_last;
	} frt_stat_t;

endpackage

// File: hw/rtl/frt_ctrl.sv
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: load, then slot scan, decision and update, or an expire walk, then result hand-off.
// ----------------------------------------------------------------------------
module frt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  frt_pkg::frt_stat_t stat,
	output frt_pkg::frt_cmd_t  cmd
);
	import frt_pkg::*;

	frt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_SCAN;
			S_SCAN: begin
				if (stat.is_expire) state_d = S_EXPIRE;
				else if (stat.quick) state_d = S_OUT;
				else if (stat.scan_last) state_d = S_DECIDE;
			end
			S_EXPIRE: if (stat.scan_last) state_d = S_OUT;
			S_DECIDE: state_d = S_UPDATE;
			S_UPDATE: state_d = S_OUT;
			S_OUT:    if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN:   cmd.scan = !stat.is_expire && !stat.quick;
			S_EXPIRE: cmd.expire = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_UPDATE: cmd.update = 1'b1;
			S_OUT: begin
				out_valid    = 1'b1;
				cmd.out_take = out_ready;
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/frt_datapath.sv
// ----------------------------------------------------------------------------
// frt_datapath
// Slot table, scan counter, key compare and result register.
// ----------------------------------------------------------------------------
module frt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  frt_pkg::frt_cmd_t  cmd,
	output frt_pkg::frt_stat_t stat,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               command,
	input  logic [15:0]        sender_id,
	input  logic [15:0]        epoch_number,
	input  logic [15:0]        sequence_number,
	input  logic [7:0]         frag_index,
	input  logic [7:0]         frag_count,
	input  logic [8:0]         fragment_length,
	input  logic [31:0]        now_time,
	output logic [2:0]         status,
	output logic               message_ready,
	output logic [2:0]         slot_number,
	output logic [5:0]         buffer_fragment,
	output logic [14:0]        message_length,
	output logic [3:0]         evicted_count
);
	import frt_pkg::*;

	logic [31:0] timeout_q;
	logic [3:0]  limit_q;

	logic [STREAMS-1:0] valid_q;
	logic [47:0] key_m   [STREAMS];
	logic [6:0]  total_m [STREAMS];
	logic [63:0] map_m   [STREAMS];
	logic [6:0]  cnt_m   [STREAMS];
	logic [14:0] bytes_m [STREAMS];
	logic [31:0] seen_m  [STREAMS];

	logic        cmd_q;
	logic [47:0] key_q;
	logic [7:0]  fidx_q, fcnt_q;
	logic [8:0]  flen_q;
	logic [31:0] now_q;

	logic [SLOT_W-1:0] idx_q;
	logic [3:0]  used_q;
	logic        found_q, hfree_q;
	logic [SLOT_W-1:0] slot_q, free_q;
	logic [3:0]  evict_q;
	logic        new_q;

	logic [2:0]  st_q;
	logic        rdy_q;
	logic [2:0]  sl_q;
	logic [5:0]  bf_q;
	logic [14:0] len_q;

	logic [8:0]  flen_c;
	logic [3:0]  lim_c;
	assign flen_c = (flen_q > 9'(MAX_FRAG_BYTES)) ? 9'(MAX_FRAG_BYTES) : flen_q;
	assign lim_c  = (limit_q > 4'(STREAMS)) ? 4'(STREAMS) : limit_q;

	assign stat.is_expire = cmd_q;
	assign stat.quick     = (fcnt_q == 8'd1) || (fcnt_q > 8'(MAX_FRAGS));
	assign stat.scan_last = (idx_q == SLOT_W'(STREAMS-1));

	// Working slot, chosen at decision time.
	logic [SLOT_W-1:0] ws_c;
	assign ws_c = found_q ? slot_q : free_q;

	logic [15:0] bsum_c;
	logic [6:0]  ncnt_c;
	logic        dup_c;
	assign bsum_c = 16'(bytes_m[ws_c]) + 16'(flen_c);
	assign ncnt_c = cnt_m[ws_c] + 7'd1;
	assign dup_c  = (fidx_q >= {1'b0, total_m[ws_c]}) || (fidx_q > 8'd63) ||
		map_m[ws_c][fidx_q[5:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd1000;
			limit_q   <= 4'd8;
		end else if (cfg_we) begin
			if (cfg_index == REG_TIMEOUT) timeout_q <= cfg_data;
			else limit_q <= cfg_data[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.expire) begin
			if (valid_q[idx_q] && ((now_q - seen_m[idx_q]) > timeout_q))
				valid_q[idx_q] <= 1'b0;
		end else if (cmd.decide) begin
			if (found_q && total_m[slot_q] != fcnt_q[6:0]) valid_q[slot_q] <= 1'b0;
		end else if (cmd.update) begin
			if (new_q || found_q) begin
				valid_q[ws_c] <= !(!dup_c && ncnt_c >= total_m[ws_c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			key_q   <= {sender_id, epoch_number, sequence_number};
			fidx_q  <= frag_index;
			fcnt_q  <= frag_count;
			flen_q  <= fragment_length;
			now_q   <= now_time;
			idx_q   <= '0;
			used_q  <= '0;
			found_q <= 1'b0;
			hfree_q <= 1'b0;
			slot_q  <= '0;
			free_q  <= '0;
			evict_q <= '0;
			new_q   <= 1'b0;
		end
		if (cmd.scan) begin
			if (valid_q[idx_q]) begin
				used_q <= used_q + 4'd1;
				if (!found_q && key_m[idx_q] == key_q) begin
					found_q <= 1'b1;
					slot_q  <= idx_q;
				end
			end else if (!hfree_q) begin
				hfree_q <= 1'b1;
				free_q  <= idx_q;
			end
			idx_q <= idx_q + SLOT_W'(1);
		end
		if (cmd.expire) begin
			if (valid_q[idx_q] && ((now_q - seen_m[idx_q]) > timeout_q))
				evict_q <= evict_q + 4'd1;
			idx_q <= idx_q + SLOT_W'(1);
		end
		// Quick cases produce their result straight from the loaded fields.
		if (stat.quick && !cmd_q && !cmd.scan && !cmd.decide && !cmd.update &&
			!cmd.expire && !cmd.load && !cmd.out_take) begin
			st_q  <= (fcnt_q == 8'd1) ? ST_SINGLE : ST_TOO_MANY;
			rdy_q <= (fcnt_q == 8'd1);
			sl_q  <= '0;
			bf_q  <= '0;
			len_q <= (fcnt_q == 8'd1) ? 15'(flen_c) : 15'd0;
		end
		if (cmd.expire && stat.scan_last) begin
			st_q  <= ST_EXPIRED;
			rdy_q <= 1'b0;
			sl_q  <= '0;
			bf_q  <= '0;
			len_q <= '0;
		end
		if (cmd.decide) begin
			sl_q  <= '0;
			bf_q  <= '0;
			len_q <= '0;
			rdy_q <= 1'b0;
			if (!found_q) begin
				if (used_q >= lim_c || !hfree_q) begin
					st_q <= ST_FULL;
				end else if (fcnt_q == 8'd0) begin
					st_q  <= ST_COMPLETE;
					rdy_q <= 1'b1;
				end else begin
					new_q             <= 1'b1;
					key_m[free_q]     <= key_q;
					total_m[free_q]   <= fcnt_q[6:0];
					map_m[free_q]     <= '0;
					cnt_m[free_q]     <= '0;
					bytes_m[free_q]   <= '0;
				end
			end else if (total_m[slot_q] != fcnt_q[6:0]) begin
				st_q    <= ST_MISMATCH;
				sl_q    <= slot_q;
				found_q <= 1'b0;
			end
		end
		if (cmd.update && (new_q || found_q)) begin
			seen_m[ws_c] <= now_q;
			sl_q <= ws_c;
			if (dup_c) begin
				st_q <= ST_DUPLICATE;
			end else begin
				map_m[ws_c][fidx_q[5:0]] <= 1'b1;
				cnt_m[ws_c]   <= ncnt_c;
				bytes_m[ws_c] <= (bsum_c > 16'(LEN_MAX)) ? LEN_MAX : bsum_c[14:0];
				bf_q <= fidx_q[5:0];
				if (ncnt_c < total_m[ws_c]) begin
					st_q <= ST_WAITING;
				end else begin
					st_q  <= ST_COMPLETE;
					rdy_q <= 1'b1;
					len_q <= (bsum_c > 16'(LEN_MAX)) ? LEN_MAX : bsum_c[14:0];
				end
			end
		end
	end

	assign status          = st_q;
	assign message_ready   = rdy_q;
	assign slot_number     = sl_q;
	assign buffer_fragment = bf_q;
	assign message_length  = len_q;
	assign evicted_count   = (cmd_q) ? evict_q : 4'd0;

endmodule

// File: hw/rtl/fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks fragmented messages in an eight-slot table and reports each outcome.
// ----------------------------------------------------------------------------
// One input item (a fragment or an expire request) enters on in_valid and
// in_ready; exactly one result item leaves on out_valid and out_ready.
// The block handles one item at a time. A fragment walks the eight slots,
// one per cycle, to find its key and a free slot, then takes a decision
// step and an update step before the result. Single-fragment and too-many
// items skip the walk. An expire item walks the slots once comparing ages.
// A new item is taken in the cycle after the result is accepted. While the
// receiver stalls the result stays in the output register and no input is
// accepted. Reset empties the table and sets expire_timeout to 1000 and
// stream_limit to 8. Configuration writes are registered.
module fragment_reassembly_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] sender_id,
	input  logic [15:0] epoch_number,
	input  logic [15:0] sequence_number,
	input  logic [7:0]  frag_index,
	input  logic [7:0]  frag_count,
	input  logic [8:0]  fragment_length,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        message_ready,
	output logic [2:0]  slot_number,
	output logic [5:0]  buffer_fragment,
	output logic [14:0] message_length,
	output logic [3:0]  evicted_count
);
	import frt_pkg::*;

	frt_cmd_t  cmd;
	frt_stat_t stat;

	frt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	frt_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.command         (command),
		.sender_id       (sender_id),
		.epoch_number    (epoch_number),
		.sequence_number (sequence_number),
		.frag_index      (frag_index),
		.frag_count      (frag_count),
		.fragment_length (fragment_length),
		.now_time        (now_time),
		.status          (status),
		.message_ready   (message_ready),
		.slot_number     (slot_number),
		.buffer_fragment (buffer_fragment),
		.message_length  (message_length),
		.evicted_count   (evicted_count)
	);

endmodule

// File: test/fragment_reassembly_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_tb
// Checks the tracker against a table model kept in the bench. Directed
// fragments cover singles, zero counts, mismatches, duplicates, full tables
// and expiry; then random whole messages are sent in shuffled order, with noise,
// under several register settings and with random stalls on both sides.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_tb;
	import frt_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [15:0] sid;
		logic [15:0] epo;
		logic [15:0] seq;
		logic [7:0]  fidx;
		logic [7:0]  fcnt;
		logic [8:0]  flen;
		logic [31:0] now;
	} frag_t;

	typedef struct packed {
		logic [2:0]  st;
		logic        rdy;
		logic [2:0]  slot;
		logic [5:0]  bfrag;
		logic [14:0] len;
		logic [3:0]  evicted;
	} outcome_t;

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic command;
	logic [15:0] sender_id, epoch_number, sequence_number;
	logic [7:0] frag_index, frag_count;
	logic [8:0] fragment_length;
	logic [31:0] now_time;
	logic [2:0] status, slot_number;
	logic message_ready;
	logic [5:0] buffer_fragment;
	logic [14:0] message_length;
	logic [3:0] evicted_count;

	fragment_reassembly_tracker u_dut (.*);

	// Model of the slot table.
	logic [31:0] m_timeout;
	logic [3:0]  m_limit;
	logic        m_valid [STREAMS];
	logic [47:0] m_key [STREAMS];
	logic [7:0]  m_total [STREAMS];
	logic [63:0] m_map [STREAMS];
	logic [7:0]  m_count [STREAMS];
	logic [14:0] m_bytes [STREAMS];
	logic [31:0] m_seen [STREAMS];

	frag_t    pending_frags[$];
	outcome_t expected_outcomes[$];
	int       sender_idle, receiver_idle, hold_off, errors, accepted_out;
	int       stall_cycles, quiet_cycles;
	logic [31:0] clock_ms;

	function automatic outcome_t mk(logic [2:0] st, logic rdy, int slot, int bf, int len,
			int ev);
		outcome_t o;
		o.st = st; o.rdy = rdy; o.slot = slot[2:0]; o.bfrag = bf[5:0];
		o.len = (len > 32767) ? 15'h7fff : len[14:0];
		o.evicted = (ev > 15) ? 4'd15 : ev[3:0];
		return o;
	endfunction

	function automatic outcome_t track_fragment(frag_t f);
		int used, slot, free_slot, lim, flen, ev;
		bit found, have_free;
		logic [47:0] key;
		used = 0; slot = 0; free_slot = 0; found = 0; have_free = 0; ev = 0;
		if (f.cmd) begin
			for (int i = 0; i < STREAMS; i++)
				if (m_valid[i] && (f.now - m_seen[i]) > m_timeout) begin
					m_valid[i] = 0;
					ev++;
				end
			return mk(ST_EXPIRED, 0, 0, 0, 0, ev);
		end
		key = {f.sid, f.epo, f.seq};
		flen = (f.flen > MAX_FRAG_BYTES) ? MAX_FRAG_BYTES : f.flen;
		lim = (m_limit > STREAMS) ? STREAMS : m_limit;
		if (f.fcnt == 1) return mk(ST_SINGLE, 1, 0, 0, flen, 0);
		if (f.fcnt > MAX_FRAGS) return mk(ST_TOO_MANY, 0, 0, 0, 0, 0);
		for (int i = 0; i < STREAMS; i++) begin
			if (m_valid[i]) begin
				used++;
				if (!found && m_key[i] == key) begin
					found = 1;
					slot = i;
				end
			end else if (!have_free) begin
				have_free = 1;
				free_slot = i;
			end
		end
		if (!found) begin
			if (used >= lim || !have_free) return mk(ST_FULL, 0, 0, 0, 0, 0);
			if (f.fcnt == 0) return mk(ST_COMPLETE, 1, 0, 0, 0, 0);
			slot = free_slot;
			m_valid[slot] = 1; m_key[slot] = key; m_total[slot] = f.fcnt;
			m_map[slot] = '0; m_count[slot] = 0; m_bytes[slot] = 0;
		end else if (m_total[slot] != f.fcnt) begin
			m_valid[slot] = 0;
			return mk(ST_MISMATCH, 0, slot, 0, 0, 0);
		end
		m_seen[slot] = f.now;
		if (f.fidx >= m_total[slot] || f.fidx > 63 || m_map[slot][f.fidx[5:0]])
			return mk(ST_DUPLICATE, 0, slot, 0, 0, 0);
		m_map[slot][f.fidx[5:0]] = 1'b1;
		m_count[slot]++;
		m_bytes[slot] = (m_bytes[slot] + flen > 32767) ? 15'h7fff :
			15'(m_bytes[slot] + flen);
		if (m_count[slot] < m_total[slot])
			return mk(ST_WAITING, 0, slot, f.fidx, 0, 0);
		m_valid[slot] = 0;
		return mk(ST_COMPLETE, 1, slot, f.fidx, m_bytes[slot], 0);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Driver: offers queued items, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{command, sender_id, epoch_number, sequence_number, frag_index, frag_count,
				fragment_length, now_time} <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_outcomes = {expected_outcomes, track_fragment({command, sender_id,
					epoch_number, sequence_number, frag_index, frag_count, fragment_length,
					now_time})};
			end
			if (!in_valid || in_ready) begin
				if (pending_frags.size() > 0 && $urandom_range(99) >= sender_idle) begin
					frag_t f;
					f = pending_frags.pop_front();
					in_valid <= 1;
					{command, sender_id, epoch_number, sequence_number, frag_index, frag_count,
						fragment_length, now_time} <= f;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: random back-pressure, with a long hold-off when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			stall_cycles <= 0;
		end else begin
			if (out_valid && out_ready) begin
				outcome_t got, want;
				got = {status, message_ready, slot_number, buffer_fragment, message_length,
					evicted_count};
				accepted_out++;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch st/rdy/slot/frag/len/ev %s %0d/%0d/%0d/%0d/%0d/%0d",
							$time, "expected", want.st, want.rdy, want.slot, want.bfrag,
							want.len, want.evicted);
						$display("%0t: mismatch st/rdy/slot/frag/len/ev %s %0d/%0d/%0d/%0d/%0d/%0d",
							$time, "actual", got.st, got.rdy, got.slot, got.bfrag,
							got.len, got.evicted);
						errors++;
					end
				end
			end
			if (hold_off > 0 && stall_cycles < hold_off) begin
				stall_cycles <= stall_cycles + 1;
				out_ready <= 0;
			end else begin
				if (hold_off == 0) stall_cycles <= 0;
				out_ready <= ($urandom_range(99) >= receiver_idle);
			end
		end
	end

	// Watchdog on cycles with no handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic frag_t frag(logic [47:0] key, int idx, int cnt, int len);
		frag_t f;
		clock_ms += $urandom_range(40);
		f.cmd = 0; {f.sid, f.epo, f.seq} = key;
		f.fidx = idx[7:0]; f.fcnt = cnt[7:0]; f.flen = len[8:0]; f.now = clock_ms;
		return f;
	endfunction

	function automatic frag_t expire_req(logic [31:0] at);
		frag_t f;
		f = '0;
		f.cmd = 1; f.sid = 16'($urandom); f.epo = 16'($urandom); f.seq = 16'($urandom);
		f.fidx = 8'($urandom); f.fcnt = 8'($urandom); f.flen = 9'($urandom); f.now = at;
		return f;
	endfunction

	task automatic add_frag(frag_t f);
		pending_frags = {pending_frags, f};
	endtask

	// Queue one message's fragments in shuffled order, sometimes with a
	// duplicate or a wrong count thrown in.
	task automatic queue_message(logic [47:0] key, int cnt);
		int order[$];
		for (int i = 0; i < cnt; i++) order = {order, i};
		order.shuffle();
		foreach (order[i]) begin
			add_frag(frag(key, order[i], cnt, $urandom_range(511)));
			if ($urandom_range(19) == 0)
				add_frag(frag(key, order[i], cnt, $urandom_range(256)));
		end
		if ($urandom_range(29) == 0)
			add_frag(frag(key, 0, cnt + 1, 5));
	endtask

	task automatic run_queued();
		wait (pending_frags.size() == 0 && !in_valid);
		wait (expected_outcomes.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_TIMEOUT) m_timeout = val; else m_limit = val[3:0];
	endtask

	task automatic random_phase(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			int pick, cnt;
			logic [47:0] key;
			pick = $urandom_range(99);
			key = 48'({$urandom, $urandom}) & (($urandom_range(3) == 0) ? 48'hffffffffffff :
				48'h000300030007);
			if (pick < 55) begin
				cnt = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(2, 6);
				queue_message(key, cnt);
				sent += cnt;
			end else if (pick < 85) begin
				add_frag(frag(key, $urandom_range(255), $urandom_range(255),
					$urandom_range(511)));
				sent++;
			end else begin
				add_frag(expire_req(clock_ms + $urandom_range(3000)));
				sent++;
			end
		end
	endtask

	initial begin
		logic [47:0] k;
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		sender_idle = 26; receiver_idle = 69; hold_off = 0;
		errors = 0; accepted_out = 0; quiet_cycles = 0; clock_ms = 32'hffff_ff00;
		m_timeout = 1000; m_limit = 8;
		for (int i = 0; i < STREAMS; i++) m_valid[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// Directed: single, too many, zero count, mismatch, duplicate, range, expiry.
		k = 48'h0001_0002_0003;
		add_frag(frag(48'hffff_ffff_ffff, 255, 1, 511));
		add_frag(frag(48'h0, 0, 1, 0));
		add_frag(frag(k, 0, 65, 10));
		add_frag(frag(k, 0, 255, 10));
		add_frag(frag(k, 0, 0, 10));
		add_frag(frag(k, 1, 3, 256));
		add_frag(frag(k, 1, 3, 256));
		add_frag(frag(k, 5, 3, 256));
		add_frag(frag(k, 0, 4, 1));
		add_frag(frag(k, 63, 64, 300));
		add_frag(frag(k, 64, 64, 300));
		add_frag(frag(k, 255, 64, 300));
		for (int i = 0; i < 9; i++)
			add_frag(frag({16'h00aa, 16'h0, i[15:0]}, 0, 2, 7));
		add_frag(frag(k, 0, 0, 1));
		add_frag(expire_req(clock_ms));
		add_frag(expire_req(clock_ms + 5000));
		run_queued();

		// Full length message of MAX_FRAGS fragments; its byte total stays below LEN_MAX.
		queue_message(48'h1234_5678_9abc, 64);
		run_queued();

		// Long receiver hold-off so that the input stalls.
		sender_idle = 0;
		hold_off = 300;
		random_phase(20);
		wait (stall_cycles >= hold_off);
		hold_off = 0;
		run_queued();

		write_reg(REG_LIMIT, 0);
		random_phase(20);
		run_queued();
		write_reg(REG_LIMIT, 15);
		write_reg(REG_TIMEOUT, 0);
		sender_idle = 26; receiver_idle = 69;
		random_phase(150);
		run_queued();
		write_reg(REG_TIMEOUT, 32'hffff_ffff);
		write_reg(REG_LIMIT, 3);
		sender_idle = 69; receiver_idle = 26;
		random_phase(150);
		run_queued();
		write_reg(REG_TIMEOUT, 500);
		write_reg(REG_LIMIT, 8);
		sender_idle = 0; receiver_idle = 0;
		random_phase(200);
		run_queued();

		$display("Run covered %0d results over singles, whole and broken messages,", accepted_out);
		$display("expiry, full tables and several timeout and limit settings.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
